// ----- src/fbpa_pkg.sv -----
// Package with the shared types and codes of the fixed block pool allocator.
`timescale 1ns / 1ps
`default_nettype none

package fbpa_pkg;

	// Operation codes of a request word.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Configuration register indexes.
	localparam int CFG_INDEX_WIDTH = 4;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OBJECT_SIZE      = 4'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OBJECT_ALIGNMENT = 4'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BLOCK_COUNT      = 4'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_POOL_BASE        = 4'd3;

	// Reset values of the configuration registers.
	localparam logic [15:0] RESET_OBJECT_SIZE      = 16'd16;
	localparam logic [7:0]  RESET_OBJECT_ALIGNMENT = 8'd8;
	localparam logic [8:0]  RESET_BLOCK_COUNT      = 9'd256;
	localparam logic [31:0] RESET_POOL_BASE        = 32'd0;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_BAD_REQ   = 2'd1,
		STATUS_EMPTY     = 2'd2,
		STATUS_BAD_INDEX = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic        op;
		logic [15:0] request_size;
		logic [7:0]  request_alignment;
		logic [7:0]  free_index;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  block_index;
		logic [31:0] block_address;
		logic [23:0] used_bytes;
	} rsp_t;

	typedef struct packed {
		logic [15:0] object_size;
		logic [7:0]  object_alignment;
		logic [8:0]  block_count;
		logic [31:0] pool_base;
	} cfg_t;

endpackage

`default_nettype wire

// ----- src/fbpa_req_if.sv -----
// Request channel interface of the fixed block pool allocator.
`timescale 1ns / 1ps
`default_nettype none

interface fbpa_req_if import fbpa_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/fbpa_rsp_if.sv -----
// Response channel interface of the fixed block pool allocator.
`timescale 1ns / 1ps
`default_nettype none

interface fbpa_rsp_if import fbpa_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/fbpa_cfg_if.sv -----
// Configuration write channel interface of the fixed block pool allocator.
`timescale 1ns / 1ps
`default_nettype none

interface fbpa_cfg_if import fbpa_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [CFG_INDEX_WIDTH-1:0] index;
	logic [31:0]                data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/fixed_block_pool_allocator.sv -----
// Top level of the fixed block pool allocator: request engine and free list.
`timescale 1ns / 1ps
`default_nettype none

// The block hands out fixed-size blocks of a pool. Each request word on req either
// allocates a block (op 0, with size and alignment that must equal the configured
// ones) or frees one (op 1, with its index). Every request gives exactly one
// response word on rsp with a status, the block index and address of a successful
// allocation, and the byte count in use after the request.
// Freed blocks form a LIFO list whose links sit in a single-port-read link memory;
// blocks never handed out are taken in ascending order from a watermark counter.
// In the accept cycle (ST_IDLE) the link memory is read at the list head and the
// index times object_size product is registered; in the update state (ST_EXEC)
// the head, watermark and byte count are updated, a free writes its link, and the
// response word is loaded into the output register. No new request is taken until
// the current one has left ST_EXEC, since req.ready is high only in ST_IDLE.
// A new request is accepted while a response word still waits in the output
// register; if rsp stalls, the following request waits in its update state until
// the output register is taken, and req.ready stays low meanwhile.
// Reset (arst_n low) empties the list and clears the watermark and byte count, so
// the whole pool is free at once with no clearing pass. Configuration words on cfg
// are always taken and must be written only while no request is in flight.

module fixed_block_pool_allocator import fbpa_pkg::*; #(
	parameter int MAX_BLOCKS    = 256,
	parameter int ADDRESS_WIDTH = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	fbpa_req_if.sink   req,
	fbpa_rsp_if.source rsp,
	fbpa_cfg_if.sink   cfg
);

	// Index width of a block, watermark width, and a width that holds both the
	// configured block count and MAX_BLOCKS for comparisons.
	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int MW = $clog2(MAX_BLOCKS + 1);
	localparam int CW = (MW > 9) ? MW : 9;
	localparam int PW = IW + 16;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_BLOCKS);

	cfg_t regs;

	fbpa_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Control state.
	state_t          state_q, state_d;
	logic [IW-1:0]   head_q;
	logic            head_valid_q;
	logic [MW-1:0]   mark_q;
	logic [23:0]     used_q;
	logic            out_valid_q;
	rsp_t            rsp_q;

	// Request carried from the accept cycle to the update cycle.
	req_t            req_s1;
	logic [IW-1:0]   idx_s1;
	logic [PW-1:0]   prod_s1;

	logic            in_fire;
	logic            commit;
	logic [IW-1:0]   idx_sel;
	logic [PW-1:0]   prod;
	logic [CW-1:0]   count_use;

	logic [IW-1:0]   link_rd;
	logic            link_we;
	logic [IW-1:0]   link_waddr;
	logic [IW-1:0]   link_wdata;

	logic [IW-1:0]   head_d;
	logic            head_valid_d;
	logic [MW-1:0]   mark_d;
	logic [23:0]     used_d;
	rsp_t            rsp_d;
	logic [ADDRESS_WIDTH-1:0] addr;

	// The link memory is read only in the accept cycle and written only in the
	// update cycle, and an accept never shares a cycle with an update, so a read
	// always sees the last write and needs no forwarding.
	fbpa_link_mem #(
		.DEPTH (MAX_BLOCKS),
		.WIDTH (IW)
	) u_link_mem (
		.clk     (clk),
		.wr_en   (link_we),
		.wr_addr (link_waddr),
		.wr_data (link_wdata),
		.rd_en   (in_fire),
		.rd_addr (head_q),
		.rd_data (link_rd)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (commit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake outputs of the state machine.
	always_comb begin
		req.ready = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_EXEC: commit    = !out_valid_q || rsp.ready;
			default: begin
			end
		endcase
	end

	assign in_fire = req.valid && req.ready;

	// A block count beyond the memory depth counts as the full depth.
	assign count_use = (CW'(regs.block_count) > MAX_C) ? MAX_C : CW'(regs.block_count);

	// The block an allocation would take is known before the link read returns,
	// so its address product is formed in the accept cycle.
	assign idx_sel = head_valid_q ? head_q : IW'(mark_q);
	assign prod    = PW'(idx_sel) * PW'(regs.object_size);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_s1  <= req.data;
			idx_s1  <= idx_sel;
			prod_s1 <= prod;
		end
	end

	assign addr = ADDRESS_WIDTH'(regs.pool_base) + ADDRESS_WIDTH'(prod_s1);

	// Update cycle: decide the outcome and build the response word.
	always_comb begin
		head_d         = head_q;
		head_valid_d   = head_valid_q;
		mark_d         = mark_q;
		used_d         = used_q;
		link_we        = 1'b0;
		link_waddr     = IW'(req_s1.free_index);
		link_wdata     = head_valid_q ? head_q : IW'(req_s1.free_index);
		rsp_d.status        = STATUS_OK;
		rsp_d.block_index   = '0;
		rsp_d.block_address = '0;

		if (req_s1.op == OP_ALLOC) begin
			priority if (req_s1.request_size == 16'd0 || req_s1.request_alignment == 8'd0 ||
			             req_s1.request_size != regs.object_size ||
			             req_s1.request_alignment != regs.object_alignment) begin
				rsp_d.status = STATUS_BAD_REQ;
			end else if (head_valid_q) begin
				// A block that links to itself is the last one on the list.
				head_d       = link_rd;
				head_valid_d = (link_rd != head_q);
			end else if (CW'(mark_q) < count_use) begin
				mark_d = mark_q + MW'(1);
			end else begin
				rsp_d.status = STATUS_EMPTY;
			end
			if (rsp_d.status == STATUS_OK) begin
				rsp_d.block_index   = 8'(idx_s1);
				rsp_d.block_address = 32'(addr);
				used_d              = used_q + 24'(regs.object_size);
			end
		end else begin
			if (CW'(req_s1.free_index) >= count_use) begin
				rsp_d.status = STATUS_BAD_INDEX;
			end else begin
				link_we      = commit;
				head_d       = IW'(req_s1.free_index);
				head_valid_d = 1'b1;
				used_d       = used_q - 24'(regs.object_size);
			end
		end
		rsp_d.used_bytes = used_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			head_valid_q <= 1'b0;
			mark_q       <= '0;
			used_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				head_q       <= head_d;
				head_valid_q <= head_valid_d;
				mark_q       <= mark_d;
				used_q       <= used_d;
				out_valid_q  <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = rsp_q;

`ifndef SYNTHESIS
	// An accepted request always moves on to its update cycle.
	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == ST_EXEC)
		else $error("accepted request did not enter its update cycle");

	// A response word appears only out of an update cycle.
	a_rsp_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EXEC))
		else $error("response word loaded outside an update cycle");

	// A refused or failed request reports neither index nor address.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rsp_q.status != STATUS_OK) |->
		(rsp_q.block_index == 8'd0 && rsp_q.block_address == 32'd0))
		else $error("failed request reports a block");

	// The watermark never passes the memory depth.
	a_mark_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mark_q <= MW'(MAX_BLOCKS))
		else $error("watermark beyond the pool");
`endif

endmodule

`default_nettype wire

// ----- src/fbpa_cfg_regs.sv -----
// Configuration register file of the fixed block pool allocator.
`timescale 1ns / 1ps
`default_nettype none

module fbpa_cfg_regs import fbpa_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	fbpa_cfg_if.sink  cfg,
	output cfg_t      regs
);

	cfg_t regs_q;

	// Writes are always taken at once.
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.object_size      <= RESET_OBJECT_SIZE;
			regs_q.object_alignment <= RESET_OBJECT_ALIGNMENT;
			regs_q.block_count      <= RESET_BLOCK_COUNT;
			regs_q.pool_base        <= RESET_POOL_BASE;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_OBJECT_SIZE:      regs_q.object_size      <= cfg.data[15:0];
				CFG_OBJECT_ALIGNMENT: regs_q.object_alignment <= cfg.data[7:0];
				CFG_BLOCK_COUNT:      regs_q.block_count      <= cfg.data[8:0];
				CFG_POOL_BASE:        regs_q.pool_base        <= cfg.data[31:0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- src/fbpa_link_mem.sv -----
// Link memory of the free list: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module fbpa_link_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	assign rd_data = rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- sim/fbpa_checker.sv -----
// Checker that predicts every response word of the block pool allocator and compares it.
`timescale 1ns / 1ps

module fbpa_checker import fbpa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	fbpa_req_if  req,
	fbpa_rsp_if  rsp,
	fbpa_cfg_if  cfg,
	output int   failure_count,
	output int   pending_count,
	output int   checked_count
);

	localparam int         POOL_SLOTS = 256;
	localparam logic [8:0] LIST_EMPTY = 9'(POOL_SLOTS);

	logic [7:0]  link_mem [POOL_SLOTS];
	logic [8:0]  free_head;
	logic [8:0]  fresh_mark;
	logic [23:0] bytes_in_use;
	cfg_t        live_cfg;
	rsp_t        predicted_responses [$];

	// Applies one request word to the shadow pool and returns the response it should give.
	function automatic rsp_t apply_request(req_t r);
		rsp_t       o;
		int         usable;
		logic [7:0] nxt;
		o = '0;
		o.status = STATUS_OK;
		usable = (live_cfg.block_count > 9'(POOL_SLOTS)) ? POOL_SLOTS :
			int'(live_cfg.block_count);
		if (r.op == OP_ALLOC) begin
			if (r.request_size == 16'd0 || r.request_alignment == 8'd0 ||
			    r.request_size != live_cfg.object_size ||
			    r.request_alignment != live_cfg.object_alignment) begin
				o.status = STATUS_BAD_REQ;
			end else if (free_head != LIST_EMPTY) begin
				// A block that links to itself is the last one on the list.
				o.block_index = free_head[7:0];
				nxt = link_mem[free_head[7:0]];
				free_head = (nxt == free_head[7:0]) ? LIST_EMPTY : {1'b0, nxt};
			end else if (int'(fresh_mark) < usable) begin
				o.block_index = fresh_mark[7:0];
				fresh_mark = fresh_mark + 9'd1;
			end else begin
				o.status = STATUS_EMPTY;
			end
			if (o.status == STATUS_OK) begin
				o.block_address = live_cfg.pool_base +
					{24'd0, o.block_index} * {16'd0, live_cfg.object_size};
				bytes_in_use = bytes_in_use + {8'd0, live_cfg.object_size};
			end
		end else if (int'(r.free_index) >= usable) begin
			o.status = STATUS_BAD_INDEX;
		end else begin
			link_mem[r.free_index] = (free_head != LIST_EMPTY) ? free_head[7:0] : r.free_index;
			free_head = {1'b0, r.free_index};
			bytes_in_use = bytes_in_use - {8'd0, live_cfg.object_size};
		end
		o.used_bytes = bytes_in_use;
		return o;
	endfunction

	task automatic note_mismatch(input string what);
		$display("[%0t] allocator mismatch: %s", $time, what);
		failure_count++;
	endtask

	task automatic compare_response(input rsp_t got);
		rsp_t want;
		if (predicted_responses.size() == 0) begin
			note_mismatch("response word arrived with none outstanding");
		end else begin
			want = predicted_responses.pop_front();
			checked_count++;
			if (got.status !== want.status)
				note_mismatch($sformatf("status field expected %0d, got %0d",
					want.status, got.status));
			if (got.block_index !== want.block_index)
				note_mismatch($sformatf("block_index expected %0d, got %0d",
					want.block_index, got.block_index));
			if (got.block_address !== want.block_address)
				note_mismatch($sformatf("block_address expected %h, got %h",
					want.block_address, got.block_address));
			if (got.used_bytes !== want.used_bytes)
				note_mismatch($sformatf("used_bytes expected %0d, got %0d",
					want.used_bytes, got.used_bytes));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			predicted_responses.delete();
			free_head = LIST_EMPTY;
			fresh_mark = '0;
			bytes_in_use = '0;
			live_cfg.object_size = RESET_OBJECT_SIZE;
			live_cfg.object_alignment = RESET_OBJECT_ALIGNMENT;
			live_cfg.block_count = RESET_BLOCK_COUNT;
			live_cfg.pool_base = RESET_POOL_BASE;
			failure_count = 0;
			pending_count = 0;
			checked_count = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_OBJECT_SIZE: live_cfg.object_size = cfg.data[15:0];
					CFG_OBJECT_ALIGNMENT: live_cfg.object_alignment = cfg.data[7:0];
					CFG_BLOCK_COUNT: live_cfg.block_count = cfg.data[8:0];
					CFG_POOL_BASE: live_cfg.pool_base = cfg.data;
					default: ;
				endcase
			end
			// A response can never belong to a request taken at the same edge.
			if (rsp.valid && rsp.ready)
				compare_response(rsp.data);
			if (req.valid && req.ready)
				predicted_responses.push_back(apply_request(req.data));
			pending_count = predicted_responses.size();
		end
	end

endmodule

// ----- sim/tb_fixed_block_pool_allocator.sv -----
// Testbench top of the block pool allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator import fbpa_pkg::*; ();

	localparam int HALF_PERIOD     = 10;
	localparam int LIMIT_NS        = 8_000_000;
	localparam int RESET_CYCLES    = 11;
	localparam int RANDOM_PHASES   = 7;
	localparam int WORDS_PER_PHASE = 105;
	localparam int HOLD_CYCLES     = 80;
	localparam int DRAIN_CYCLES    = 6;

	// Ways the response side can behave between long hold-offs.
	typedef enum int {
		RX_STEADY,
		RX_COIN,
		RX_SPARSE
	} rx_mode_t;

	logic clk;
	logic arst_n;

	fbpa_req_if req_ch ();
	fbpa_rsp_if rsp_ch ();
	fbpa_cfg_if cfg_ch ();

	int failure_count;
	int pending_count;
	int checked_count;

	// The setting last loaded into the block; random words are shaped around it.
	cfg_t setting;
	int   burst_left = 0;
	int   n_alloc    = 0;
	int   n_free     = 0;
	int   n_settings = 0;
	int   hold_asked = 0;

	// Ops of requests still waiting for their response word, and the blocks that
	// successful allocations have handed out, so that most frees return a live block.
	logic       outstanding_ops [$];
	logic [7:0] handed_out [$];

	fixed_block_pool_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	fbpa_checker response_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.cfg           (cfg_ch),
		.failure_count (failure_count),
		.pending_count (pending_count),
		.checked_count (checked_count)
	);

	initial begin
		clk = 1'b0;
		forever #(HALF_PERIOD) clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#(LIMIT_NS);
		$display("status: fail");
		$finish;
	end

	// The response side stalls on a pattern of its own. Now and then the stimulus asks
	// for a long hold-off; the request side keeps offering words during it, so the
	// output register and the second request stage fill up and req.ready drops.
	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       hold_left;
		int       hold_given;
		mode = RX_STEADY;
		mode_left = 0;
		hold_left = 0;
		hold_given = 0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (hold_given != hold_asked) begin
				hold_given++;
				hold_left = HOLD_CYCLES - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					RX_STEADY: rsp_ch.ready <= 1'b1;
					RX_COIN: rsp_ch.ready <= 1'($urandom_range(0, 1));
					default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Keeps track of which blocks are out, from the words that pass on the channels.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready && outstanding_ops.size() > 0) begin
				if (outstanding_ops.pop_front() == OP_ALLOC && rsp_ch.data.status == STATUS_OK)
					handed_out.push_back(rsp_ch.data.block_index);
			end
			if (req_ch.valid && req_ch.ready)
				outstanding_ops.push_back(req_ch.data.op);
		end
	end

	function automatic req_t make_word(logic op, logic [15:0] size_b, logic [7:0] align_b,
			logic [7:0] index_b);
		req_t w;
		w.op = op;
		w.request_size = size_b;
		w.request_alignment = align_b;
		w.free_index = index_b;
		return w;
	endfunction

	// Mostly well-formed traffic: allocations that match the setting and frees of blocks
	// that are out. The rest is malformed allocations and frees of arbitrary indexes,
	// which covers double frees, frees of blocks never handed out and bad indexes.
	function automatic req_t random_word();
		int   roll;
		int   pick;
		req_t w;
		roll = $urandom_range(0, 99);
		w = make_word(OP_ALLOC, setting.object_size, setting.object_alignment, 8'($urandom));
		if (roll >= 45 && roll < 80 && handed_out.size() > 0) begin
			pick = $urandom_range(0, handed_out.size() - 1);
			w = make_word(OP_FREE, 16'($urandom), 8'($urandom), handed_out[pick]);
			handed_out.delete(pick);
		end else if (roll >= 80 && roll < 90) begin
			case ($urandom_range(0, 3))
				0: w.request_size = '0;
				1: w.request_alignment = '0;
				2: w.request_size = w.request_size ^ 16'(1 << $urandom_range(0, 15));
				default: w.request_alignment = w.request_alignment ^ 8'(1 << $urandom_range(0, 7));
			endcase
		end else if (roll >= 90) begin
			w = make_word(OP_FREE, 16'($urandom), 8'($urandom), 8'($urandom));
		end
		return w;
	endfunction

	// The first two random settings sit at the extremes; the rest favor small pools so
	// that the pool runs dry and the free list gets reused, with an occasional count
	// of zero or above the pool size.
	function automatic cfg_t pick_setting(int phase);
		cfg_t s;
		int   roll;
		if (phase == 0) begin
			s = '{16'd1, 8'd1, 9'd256, 32'd0};
		end else if (phase == 1) begin
			s = '{16'hFFFF, 8'hFF, 9'd1, 32'hFFFF_FFFF};
		end else begin
			case ($urandom_range(0, 5))
				0: s.object_size = 16'd1;
				1: s.object_size = 16'hFFFF;
				default: s.object_size = 16'($urandom_range(1, 65535));
			endcase
			case ($urandom_range(0, 5))
				0: s.object_alignment = 8'd1;
				1: s.object_alignment = 8'hFF;
				default: s.object_alignment = 8'($urandom_range(1, 255));
			endcase
			roll = $urandom_range(0, 99);
			if (roll < 55)
				s.block_count = 9'($urandom_range(1, 16));
			else if (roll < 75)
				s.block_count = 9'($urandom_range(17, 255));
			else if (roll < 87)
				s.block_count = 9'd256;
			else if (roll < 93)
				s.block_count = 9'd0;
			else
				s.block_count = 9'($urandom_range(257, 511));
			case ($urandom_range(0, 3))
				0: s.pool_base = 32'd0;
				1: s.pool_base = 32'hFFFF_FFFF;
				default: s.pool_base = $urandom;
			endcase
		end
		return s;
	endfunction

	// Offers one request word and returns at the edge where it is taken. The request
	// side works in bursts; between bursts valid stays low for a random pause.
	task automatic offer(input req_t w);
		if (burst_left == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 12);
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.data <= w;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (w.op == OP_ALLOC)
			n_alloc++;
		else
			n_free++;
	endtask

	// Stops offering, waits until every outstanding response word has been taken,
	// and then lets the request pipeline come to rest.
	task automatic settle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending_count == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes all four registers back to back; only called while the block is idle.
	task automatic load_setting(input cfg_t s);
		logic [CFG_INDEX_WIDTH-1:0] reg_index [4];
		logic [31:0]                reg_value [4];
		reg_index = '{CFG_OBJECT_SIZE, CFG_OBJECT_ALIGNMENT, CFG_BLOCK_COUNT, CFG_POOL_BASE};
		reg_value = '{{16'd0, s.object_size}, {24'd0, s.object_alignment},
			{23'd0, s.block_count}, s.pool_base};
		for (int i = 0; i < 4; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= reg_index[i];
			cfg_ch.data <= reg_value[i];
			@(posedge clk);
			while (!cfg_ch.ready) @(posedge clk);
		end
		cfg_ch.valid <= 1'b0;
		setting = s;
		n_settings++;
	endtask

	initial begin
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		arst_n = 1'b0;
		setting = '{RESET_OBJECT_SIZE, RESET_OBJECT_ALIGNMENT, RESET_BLOCK_COUNT,
			RESET_POOL_BASE};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting (16 bytes, alignment 8, 256 blocks, base 0). Malformed requests
		// first: zero size, zero alignment, all-ones fields, and a size or alignment off
		// by one. Then fresh blocks from the watermark, a free of a block never handed
		// out that lands on the empty list and links to itself, and LIFO reuse.
		offer(make_word(OP_ALLOC, 16'd0, 8'd8, 8'd0));
		offer(make_word(OP_ALLOC, 16'd16, 8'd0, 8'd0));
		offer(make_word(OP_ALLOC, 16'hFFFF, 8'hFF, 8'hFF));
		offer(make_word(OP_ALLOC, 16'd17, 8'd8, 8'd0));
		offer(make_word(OP_ALLOC, 16'd16, 8'd9, 8'd0));
		offer(make_word(OP_ALLOC, 16'd16, 8'd8, 8'hFF));
		offer(make_word(OP_ALLOC, 16'd16, 8'd8, 8'd0));
		offer(make_word(OP_FREE, 16'hFFFF, 8'hFF, 8'd255));
		offer(make_word(OP_ALLOC, 16'd16, 8'd8, 8'd0));
		offer(make_word(OP_FREE, 16'd0, 8'd0, 8'd1));
		offer(make_word(OP_FREE, 16'd0, 8'd0, 8'd0));
		offer(make_word(OP_ALLOC, 16'd16, 8'd8, 8'd0));
		offer(make_word(OP_ALLOC, 16'd16, 8'd8, 8'd0));

		// Largest size and alignment, three blocks, base at the top of the address space
		// so that addresses wrap. Frees beyond the count are refused, frees beyond the
		// allocations make the byte count wrap below zero, and a double free of the head
		// leaves a self-linked block that ends the list after one pop.
		settle();
		load_setting('{16'hFFFF, 8'hFF, 9'd3, 32'hFFFF_FFFF});
		offer(make_word(OP_ALLOC, 16'hFFFF, 8'hFF, 8'd0));
		offer(make_word(OP_ALLOC, 16'hFFFF, 8'hFF, 8'd0));
		offer(make_word(OP_FREE, 16'd0, 8'd0, 8'd3));
		offer(make_word(OP_FREE, 16'd0, 8'd0, 8'd255));
		offer(make_word(OP_FREE, 16'd0, 8'd0, 8'd1));
		offer(make_word(OP_FREE, 16'd0, 8'd0, 8'd0));
		offer(make_word(OP_FREE, 16'd0, 8'd0, 8'd2));
		offer(make_word(OP_FREE, 16'd0, 8'd0, 8'd2));
		offer(make_word(OP_ALLOC, 16'hFFFF, 8'hFF, 8'd0));
		offer(make_word(OP_ALLOC, 16'hFFFF, 8'hFF, 8'd0));

		// A block count of zero: nothing can be allocated and every free is refused.
		settle();
		load_setting('{16'd1, 8'd1, 9'd0, 32'd0});
		offer(make_word(OP_ALLOC, 16'd1, 8'd1, 8'd0));
		offer(make_word(OP_FREE, 16'd1, 8'd1, 8'd0));
		offer(make_word(OP_ALLOC, 16'd0, 8'd1, 8'd0));

		// A block count above the pool size counts as the full pool.
		settle();
		load_setting('{16'd1, 8'd1, 9'd511, 32'h8000_0000});
		offer(make_word(OP_FREE, 16'd0, 8'd0, 8'd255));
		offer(make_word(OP_ALLOC, 16'd1, 8'd1, 8'd0));
		offer(make_word(OP_ALLOC, 16'd1, 8'd1, 8'd0));

		// Random phases, each under a setting of its own. Two of them begin with a long
		// hold-off on the response side.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			load_setting(pick_setting(p));
			if (p == 2 || p == 5)
				hold_asked++;
			repeat (WORDS_PER_PHASE) offer(random_word());
		end

		settle();
		$display("run covered %0d allocate and %0d free words under %0d register settings,",
			n_alloc, n_free, n_settings);
		$display("with %0d response words checked and %0d long response hold-offs",
			checked_count, hold_asked);
		if (failure_count == 0 && pending_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- files.f -----
src/fbpa_pkg.sv
src/fbpa_req_if.sv
src/fbpa_rsp_if.sv
src/fbpa_cfg_if.sv
src/fbpa_cfg_regs.sv
src/fbpa_link_mem.sv
src/fixed_block_pool_allocator.sv
sim/fbpa_checker.sv
sim/tb_fixed_block_pool_allocator.sv
